// ----- design/assert_macros.svh -----
// Assertion helpers, included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is high.
`define CHK_PROP(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define CHK_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);

`else

`define CHK_PROP(lbl, ck, rs, prop, msg)
`define CHK_NEVER(lbl, ck, rs, expr, msg)

`endif

`endif

// ----- design/lcbcm_pkg.sv -----
package lcbcm_pkg;

  localparam int LEVEL_W = 5;
  localparam int COST_W  = 21;
  localparam int MANT_W  = 32;   // Q1.31 mantissa
  localparam int EXP_W   = 5;    // integer part of a log2
  localparam int PRIOR_DEPTH = 22;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic SEL_ALL = 1'b0;
  localparam logic SEL_NUM = 1'b1;

  localparam logic [7:0] PRIOR_ZEROS [PRIOR_DEPTH] = '{
    8'd20, 8'd17, 8'd15, 8'd10, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd1, 8'd1,
    8'd1,  8'd1,  8'd1,  8'd1,  8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1
  };
  localparam logic [7:0] PRIOR_ONES [PRIOR_DEPTH] = '{
    8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd1,  8'd2,  8'd3,
    8'd5,  8'd10, 8'd15, 8'd20, 8'd25, 8'd30, 8'd35, 8'd60, 8'd60, 8'd60, 8'd60
  };

  typedef struct packed {
    logic accept;     // take the input word, apply an update
    logic log_start;  // load the log unit
    logic log_sel;    // SEL_ALL or SEL_NUM
    logic norm_step;
    logic sq_step;
    logic save_la;    // keep log2(total)
    logic load_out;   // write the result register
  } dp_cmd_t;

  typedef struct packed {
    logic special;    // out-of-range level or zero count
    logic norm_done;
    logic sq_done;
  } dp_sts_t;

endpackage

// ----- design/lcbcm_dp.sv -----
module lcbcm_dp #(
  parameter int LEVELS     = 22,
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             child,
  input  logic [lcbcm_pkg::LEVEL_W-1:0]    level,
  input  logic                             cmd,
  input  lcbcm_pkg::dp_cmd_t               ctl,
  output lcbcm_pkg::dp_sts_t               sts,
  output logic [lcbcm_pkg::COST_W-1:0]     cost_bits
);

  localparam int LVL_IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int IT_W   = $clog2(FRAC_BITS + 1);
  localparam int MW     = lcbcm_pkg::MANT_W;
  localparam int LOG_W  = lcbcm_pkg::EXP_W + FRAC_BITS;
  localparam int WIDE_W = (LOG_W > lcbcm_pkg::COST_W) ? LOG_W : lcbcm_pkg::COST_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] ones_count [LEVELS];
  logic [COUNT_BITS-1:0] all_count  [LEVELS];

  logic                  in_range;
  logic [LVL_IW-1:0]     idx;
  logic [COUNT_BITS-1:0] rd_ones, rd_all, num_next;

  logic [COUNT_BITS-1:0] all_q, num_q;
  logic                  oor_q, zero_q;

  logic [MW-1:0]         m_q;
  logic [lcbcm_pkg::EXP_W-1:0] e_q;
  logic [FRAC_BITS-1:0]  frac_q;
  logic [IT_W-1:0]       it_q;
  logic [LOG_W-1:0]      la_q, lb;
  logic [2*MW-1:0]       sq_prod;
  logic [MW:0]           sq_t;
  logic [WIDE_W-1:0]     diff_w;
  logic [lcbcm_pkg::COST_W-1:0] cost_next;

  assign in_range = (level < lcbcm_pkg::LEVEL_W'(LEVELS));
  assign idx      = level[LVL_IW-1:0];
  assign rd_ones  = in_range ? ones_count[idx] : '0;
  assign rd_all   = in_range ? all_count[idx]  : '0;
  assign num_next = child ? rd_ones : ((rd_all >= rd_ones) ? rd_all - rd_ones : '0);

  // context counters, saturating on the total
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        ones_count[i] <= COUNT_BITS'(lcbcm_pkg::PRIOR_ONES[i]);
        all_count[i]  <= COUNT_BITS'(lcbcm_pkg::PRIOR_ONES[i] + lcbcm_pkg::PRIOR_ZEROS[i]);
      end
    end else if (ctl.accept && cmd == lcbcm_pkg::CMD_UPDATE && in_range &&
                 rd_all != COUNT_MAX) begin
      all_count[idx] <= rd_all + COUNT_BITS'(1);
      if (child) begin
        ones_count[idx] <= rd_ones + COUNT_BITS'(1);
      end
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      all_q  <= rd_all;
      num_q  <= num_next;
      oor_q  <= !in_range;
      zero_q <= (num_next == '0) || (rd_all == '0);
    end
  end

  // shared log2 unit: normalize, then square FRAC_BITS times
  assign sq_prod = m_q * m_q;
  assign sq_t    = sq_prod[2*MW-1:MW-1];

  always_ff @(posedge clk) begin
    if (ctl.log_start) begin
      m_q    <= (ctl.log_sel == lcbcm_pkg::SEL_NUM) ? MW'(num_q) : MW'(all_q);
      e_q    <= lcbcm_pkg::EXP_W'(MW - 1);
      frac_q <= '0;
      it_q   <= '0;
    end else if (ctl.norm_step) begin
      if (m_q[MW-1 -: 4] == 4'd0) begin
        m_q <= m_q << 4;
        e_q <= e_q - lcbcm_pkg::EXP_W'(4);
      end else begin
        m_q <= m_q << 1;
        e_q <= e_q - lcbcm_pkg::EXP_W'(1);
      end
    end else if (ctl.sq_step) begin
      frac_q <= {frac_q[FRAC_BITS-2:0], sq_t[MW]};
      m_q    <= sq_t[MW] ? sq_t[MW:1] : sq_t[MW-1:0];
      it_q   <= it_q + IT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.save_la) begin
      la_q <= {e_q, frac_q};
    end
  end

  assign lb     = {e_q, frac_q};
  assign diff_w = WIDE_W'(la_q) - WIDE_W'(lb);

  always_comb begin
    priority if (oor_q) begin
      cost_next = '0;
    end else if (zero_q) begin
      cost_next = lcbcm_pkg::COST_MAX;
    end else if (la_q <= lb) begin
      cost_next = '0;
    end else if (diff_w > WIDE_W'(lcbcm_pkg::COST_MAX)) begin
      cost_next = lcbcm_pkg::COST_MAX;
    end else begin
      cost_next = diff_w[lcbcm_pkg::COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      cost_bits <= cost_next;
    end
  end

  assign sts.special   = oor_q || zero_q;
  assign sts.norm_done = m_q[MW-1];
  assign sts.sq_done   = (it_q == IT_W'(FRAC_BITS));

endmodule

// ----- design/lcbcm_ctrl.sv -----
module lcbcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  output logic                out_valid,
  input  logic                out_stall,
  input  lcbcm_pkg::dp_sts_t  sts,
  output lcbcm_pkg::dp_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_START_A, S_NORM_A, S_SQ_A, S_NORM_B, S_SQ_B, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        ctl.accept = in_valid;
        if (in_valid && cmd == lcbcm_pkg::CMD_QUERY) begin
          state_next = S_START_A;
        end
      end
      S_START_A: begin
        if (sts.special) begin
          state_next = S_FINISH;
        end else begin
          ctl.log_start = 1'b1;
          ctl.log_sel   = lcbcm_pkg::SEL_ALL;
          state_next    = S_NORM_A;
        end
      end
      S_NORM_A: begin
        if (sts.norm_done) begin
          state_next = S_SQ_A;
        end else begin
          ctl.norm_step = 1'b1;
        end
      end
      S_SQ_A: begin
        if (sts.sq_done) begin
          ctl.save_la   = 1'b1;
          ctl.log_start = 1'b1;
          ctl.log_sel   = lcbcm_pkg::SEL_NUM;
          state_next    = S_NORM_B;
        end else begin
          ctl.sq_step = 1'b1;
        end
      end
      S_NORM_B: begin
        if (sts.norm_done) begin
          state_next = S_SQ_B;
        end else begin
          ctl.norm_step = 1'b1;
        end
      end
      S_SQ_B: begin
        if (sts.sq_done) begin
          state_next = S_FINISH;
        end else begin
          ctl.sq_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/level_context_bit_cost_model.sv -----
// Per-level adaptive binary context with bit cost readout.
// Input channel (in_valid / in_stall) carries one word: cmd, child, level.
//   cmd = update: the level's counts take the symbol in the accepting cycle
//   (total and, for child = 1, the ones count); no result word follows.
//   cmd = query: one result word cost_bits = log2(total) - log2(numerator),
//   unsigned, FRAC_BITS fractional bits, saturated to 21 bits.
// Output channel (out_valid / out_stall) has a result register; a finished
// query waits there while the next input word is accepted.
// A query runs two log2 passes, total then numerator, each normalizing the
// operand in a 32-bit word (a shift by four while the top four bits are
// zero, else a shift by one) and then squaring FRAC_BITS times; the single
// squaring multiplier is shared by both logarithms.
// Queries with an out-of-range level, a zero numerator or a zero total skip
// both passes and go straight to the result load.
// in_stall stays high while a query is in flight, and also while a finished
// result cannot enter the output register because out_stall holds it.
// Reset loads the prior count tables and empties the output register.
`include "assert_macros.svh"

module level_context_bit_cost_model #(
  parameter int LEVELS     = 22,
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic                          child,
  input  logic [lcbcm_pkg::LEVEL_W-1:0] level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcbcm_pkg::COST_W-1:0]  cost_bits
);

  lcbcm_pkg::dp_cmd_t ctl;
  lcbcm_pkg::dp_sts_t sts;

  // sequencer: accept, two log2 passes, result load
  lcbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // counters, operand registers, log2 unit, result register
  lcbcm_dp #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .child     (child),
    .level     (level),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .cost_bits (cost_bits)
  );

  // an update word never raises a result
  `CHK_PROP(a_upd_no_out, clk, rst,
            (in_valid && !in_stall && cmd == lcbcm_pkg::CMD_UPDATE && !out_valid) |=> !out_valid,
            "update produced a result word")

  // a query holds off the input side in the following cycle
  `CHK_PROP(a_query_busy, clk, rst,
            (in_valid && !in_stall && cmd == lcbcm_pkg::CMD_QUERY) |=> in_stall,
            "input accepted during a query")

  // the log unit takes one kind of step at a time
  `CHK_NEVER(a_one_step, clk, rst, ctl.norm_step && ctl.sq_step,
             "normalize and square issued together")

  // the result register is only written when free or draining
  `CHK_NEVER(a_no_overwrite, clk, rst, ctl.load_out && out_valid && out_stall,
             "pending result overwritten")

endmodule

// ----- verif/level_context_bit_cost_model_tb.sv -----
module level_context_bit_cost_model_tb;

  localparam int LEVELS     = 22;
  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;

  // Quiet cycles allowed before the run is called hung. This is generous: far
  // above the long receiver hold-off (HOLD_CYCLES) and a query's run time.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  // Tail after the last result: covers one query in flight with margin.
  localparam int SETTLE_CYCLES = 100;

  // One input word as the driver presents it.
  typedef struct packed {
    logic                            cmd;
    logic                            child;
    logic [lcbcm_pkg::LEVEL_W-1:0]   level;
  } ctx_word_t;

  // Expected cost, tagged with the query that caused it for the error log.
  typedef struct {
    logic                            child;
    logic [lcbcm_pkg::LEVEL_W-1:0]   level;
    logic [lcbcm_pkg::COST_W-1:0]    cost;
  } cost_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid  = 1'b0;
  logic                          cmd       = 1'b0;
  logic                          child     = 1'b0;
  logic [lcbcm_pkg::LEVEL_W-1:0] level     = '0;
  logic                          out_stall = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [lcbcm_pkg::COST_W-1:0]  cost_bits;

  level_context_bit_cost_model #(
    .LEVELS(LEVELS),
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .child(child),
    .level(level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cost_bits(cost_bits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be driven, and costs waiting to come out.
  ctx_word_t word_q[$];
  cost_exp_t cost_q[$];

  // Shadow of the per-level context counters.
  logic [COUNT_BITS-1:0] ones_seen  [LEVELS];
  logic [COUNT_BITS-1:0] total_seen [LEVELS];

  // Idle knobs (percent per cycle), set between phases by the sequencer.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // A bump of hold_reqs asks the receiver for one long hold-off.
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  int fail_count = 0;
  int quiet      = 0;
  ctx_word_t next_word;

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // log2 truncated to FRAC_BITS fraction bits. Integer part is the position
  // of the leading one; fraction bits come from squaring a Q1.31 mantissa,
  // one bit per squaring, each product truncated back to Q1.31.
  function automatic logic [31:0] trunc_log2(input logic [31:0] x);
    int          msb;
    logic [63:0] mant;
    logic [31:0] frac;
    msb = 0;
    for (int b = 0; b < 32; b++) begin
      if (x[b]) msb = b;
    end
    mant = 64'(x) << (31 - msb);
    frac = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant  = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    return (32'(msb) << FRAC_BITS) | frac;
  endfunction

  // Cost of a symbol at a level: log2(total) - log2(numerator).
  function automatic logic [lcbcm_pkg::COST_W-1:0] symbol_cost(
      input logic sym, input logic [lcbcm_pkg::LEVEL_W-1:0] lv);
    logic [COUNT_BITS-1:0] num;
    logic [31:0]           la;
    logic [31:0]           ln;
    logic [31:0]           diff;
    if (lv >= LEVELS) return '0;
    if (sym) num = ones_seen[lv];
    else if (total_seen[lv] >= ones_seen[lv]) num = total_seen[lv] - ones_seen[lv];
    else num = '0;
    // zero numerator or total: infinite cost, pinned to all ones
    if (num == 0 || total_seen[lv] == 0) return lcbcm_pkg::COST_MAX;
    la   = trunc_log2(32'(total_seen[lv]));
    ln   = trunc_log2(32'(num));
    diff = (la > ln) ? la - ln : '0;
    if (diff > 32'(lcbcm_pkg::COST_MAX)) diff = 32'(lcbcm_pkg::COST_MAX);
    return diff[lcbcm_pkg::COST_W-1:0];
  endfunction

  // Update: skipped for out-of-range levels and once the total saturates.
  function automatic void count_symbol(input logic sym,
                                       input logic [lcbcm_pkg::LEVEL_W-1:0] lv);
    if (lv < LEVELS && total_seen[lv] != {COUNT_BITS{1'b1}}) begin
      total_seen[lv] = total_seen[lv] + COUNT_BITS'(1);
      if (sym) ones_seen[lv] = ones_seen[lv] + COUNT_BITS'(1);
    end
  endfunction

  function automatic void push_word(input logic c, input logic sym, input int lv);
    ctx_word_t w;
    w.cmd   = c;
    w.child = sym;
    w.level = lv[lcbcm_pkg::LEVEL_W-1:0];
    word_q.push_back(w);
  endfunction

  // Random traffic: mostly runs of updates at one level with a chosen
  // symbol bias, closed by one or two queries at that level, so the counts
  // drift far from the priors. The rest is single random words.
  task automatic queue_traffic(input int n);
    int left;
    int lv;
    int bias;
    int len;
    int nq;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 15) begin
        push_word(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(31));
        left--;
      end else begin
        lv = ($urandom_range(9) == 0) ? $urandom_range(31, LEVELS)
                                      : $urandom_range(LEVELS - 1);
        case ($urandom_range(3))
          0: bias = 0;
          1: bias = 100;
          default: bias = $urandom_range(100);
        endcase
        len = ($urandom_range(19) == 0) ? $urandom_range(80, 40) : $urandom_range(10);
        for (int k = 0; k < len; k++) begin
          push_word(lcbcm_pkg::CMD_UPDATE, $urandom_range(99) < bias, lv);
        end
        nq = $urandom_range(2, 1);
        for (int k = 0; k < nq; k++) begin
          push_word(lcbcm_pkg::CMD_QUERY, 1'($urandom_range(1)), lv);
        end
        left -= len + nq;
      end
    end
  endtask

  // Wait until every queued word is taken and every cost has come back.
  task automatic drain();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || cost_q.size() != 0);
  endtask

  // Driver: presents queued words; predicts at the edge a word is taken.
  // The payload only moves once the current word is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cmd == lcbcm_pkg::CMD_UPDATE) begin
          count_symbol(child, level);
        end else begin
          cost_q.push_back('{child: child, level: level,
                             cost: symbol_cost(child, level)});
        end
      end
      if (!in_valid || !in_stall) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = word_q.pop_front();
          in_valid <= 1'b1;
          cmd      <= next_word.cmd;
          child    <= next_word.child;
          level    <= next_word.level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result against the oldest expected cost and
  // drives out_stall, either at random or as one long counted hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cost_q.size() == 0) begin
          flag_error($sformatf("unexpected result word, cost_bits=%0d", cost_bits));
        end else begin
          if (cost_bits !== cost_q[0].cost) begin
            flag_error($sformatf("cost_bits for level %0d child %0b: expected %0d got %0d",
                                 cost_q[0].level, cost_q[0].child, cost_q[0].cost,
                                 cost_bits));
          end
          void'(cost_q.pop_front());
        end
      end
      if (hold_done != hold_reqs) begin
        hold_done <= hold_reqs;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: any accepted word on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < LEVELS; i++) begin
      ones_seen[i]  = COUNT_BITS'(lcbcm_pkg::PRIOR_ONES[i]);
      total_seen[i] = COUNT_BITS'(lcbcm_pkg::PRIOR_ONES[i]) +
                      COUNT_BITS'(lcbcm_pkg::PRIOR_ZEROS[i]);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: priors at the table ends, out-of-range levels (update
    // ignored, query gives zero), and updates moving both counts.
    push_word(lcbcm_pkg::CMD_QUERY,  1'b0, 0);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b1, 0);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b0, LEVELS - 1);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b1, LEVELS - 1);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b1, LEVELS);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b0, 31);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b1, 31);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b0, LEVELS);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b1, 31);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b1, 0);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b1, 0);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b1, 0);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b0, 0);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b0, LEVELS - 1);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b0, LEVELS - 1);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b0, LEVELS - 1);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b0, LEVELS - 1);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b1, LEVELS - 1);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b0, 10);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b1, 10);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b0, 5);
    push_word(lcbcm_pkg::CMD_UPDATE, 1'b1, 5);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b0, 5);
    push_word(lcbcm_pkg::CMD_QUERY,  1'b1, 5);
    drain();

    // Random phases: free running, idle sender, stalling receiver, both.
    queue_traffic(200);
    drain();
    send_idle_pct = 49;
    queue_traffic(200);
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    queue_traffic(200);
    drain();
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    queue_traffic(200);
    drain();

    // Back pressure: receiver holds off while queries keep coming, so the
    // result register fills and the block stalls its input. The drain
    // after it is a sender pause until every cost is back.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    for (int k = 0; k < 30; k++) begin
      push_word(lcbcm_pkg::CMD_UPDATE, 1'($urandom_range(1)), $urandom_range(LEVELS - 1));
      push_word(lcbcm_pkg::CMD_QUERY, 1'($urandom_range(1)), $urandom_range(31));
    end
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (cost_q.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", cost_q.size()));
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
